### hdl/vsl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsl_pkg: shared types and constants for the vertex skin and light block
// Command and register codes, store sizes and the item record that travels
// down the pipeline.
// ---------------------------------------------------------------------------
package vsl_pkg;

  localparam int NUM_BONES_DEF = 128;
  localparam int MAT_WORDS     = 12;
  localparam int GAMMA_DEPTH   = 256;

  // Command codes
  localparam logic [1:0] CMD_LOAD_MAT   = 2'd0;
  localparam logic [1:0] CMD_LOAD_GAMMA = 2'd1;
  localparam logic [1:0] CMD_TRANSFORM  = 2'd2;
  localparam logic [1:0] CMD_LIGHT      = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_AMBIENT = 3'd0;
  localparam logic [2:0] REG_SHADE   = 3'd1;
  localparam logic [2:0] REG_LDIR_X  = 3'd2;
  localparam logic [2:0] REG_LDIR_Y  = 3'd3;
  localparam logic [2:0] REG_LDIR_Z  = 3'd4;
  localparam logic [2:0] REG_WRAP    = 3'd5;

  // Register reset values
  localparam logic [7:0]  AMBIENT_RST = 8'd192;
  localparam logic [15:0] SHADE_RST   = 16'd0;
  localparam logic [15:0] LDIR_X_RST  = 16'h0000;
  localparam logic [15:0] LDIR_Y_RST  = 16'h0000;
  localparam logic [15:0] LDIR_Z_RST  = 16'hC000;
  localparam logic [15:0] WRAP_RST    = 16'd384;

  // Wrap factor floor, 1.0 in Q8.8
  localparam logic [15:0] WRAP_ONE = 16'd256;

  // Item record carried from stage to stage
  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         slot;
    logic [9:0]         gval;
    logic               flat;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } item_t;

  // Matrix store write request
  typedef struct packed {
    logic               en;
    logic [3:0]         word;
    logic signed [31:0] data;
  } mat_wr_t;

endpackage

### hdl/vsl_bone_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsl_bone_store: bone matrix store
// One bank per matrix word so that a whole 3x4 matrix reads out at once.
// Registered read, held while the read enable is low.
// ---------------------------------------------------------------------------
module vsl_bone_store
  import vsl_pkg::*;
#(
  parameter int NUM_BONES = NUM_BONES_DEF,
  localparam int AW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1
) (
  input  logic                           clk,
  input  mat_wr_t                        wr,
  input  logic [AW-1:0]                  waddr,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  raddr,
  output logic [MAT_WORDS-1:0][31:0]     rdata
);

  genvar k;
  generate
    for (k = 0; k < MAT_WORDS; k++) begin : g_bank
      logic [31:0] mem [NUM_BONES];

      // write one word, read the same word of every bank
      always_ff @(posedge clk) begin
        if (wr.en && (wr.word == 4'(k))) begin
          mem[waddr] <= wr.data;
        end
        if (rd_en) begin
          rdata[k] <= mem[raddr];
        end
      end
    end
  endgenerate

endmodule

### hdl/vertex_skin_and_light.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertex_skin_and_light: vertex skinning and Lambert lighting engine
// Transforms vertices by bone matrices, rotates normals and lights them
// through a gamma table. Loads fill the matrix store and the gamma table.
// ---------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     in_valid / in_ready       cmd bone slot load_value vec_x/y/z
//                                      flat_shade
//  output    out_valid / out_ready     out_x out_y out_z light_level
//  config    psel penable pwrite       paddr pwdata prdata (pready high)
//
//  One item per cycle while out_ready holds. The pipeline depth comes
//  from the eight-stage restoring divide of the wrapped Lambert term,
//  one quotient bit per stage. Loads give no result. Each stage has its
//  own ready, so a stall on out_ready holds only the stages that are full
//  and bubbles close up. Reset clears the valid bits and sets the
//  configuration registers to their reset values; the matrix store and
//  gamma table hold nothing until written.
// ---------------------------------------------------------------------------
module vertex_skin_and_light
  import vsl_pkg::*;
#(
  parameter int NUM_BONES = NUM_BONES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [6:0]         bone,
  input  logic [7:0]         slot,
  input  logic signed [31:0] load_value,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic               flat_shade,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [9:0]         light_level,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int BAW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
  localparam int NST = 17;
  localparam int QB  = 8;

  // --------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------
  logic [7:0]         ambient;
  logic [15:0]        shade;
  logic signed [15:0] ldir_x;
  logic signed [15:0] ldir_y;
  logic signed [15:0] ldir_z;
  logic [15:0]        wrap;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ambient <= AMBIENT_RST;
      shade   <= SHADE_RST;
      ldir_x  <= LDIR_X_RST;
      ldir_y  <= LDIR_Y_RST;
      ldir_z  <= LDIR_Z_RST;
      wrap    <= WRAP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_AMBIENT: ambient <= pwdata[7:0];
        REG_SHADE:   shade   <= pwdata[15:0];
        REG_LDIR_X:  ldir_x  <= pwdata[15:0];
        REG_LDIR_Y:  ldir_y  <= pwdata[15:0];
        REG_LDIR_Z:  ldir_z  <= pwdata[15:0];
        REG_WRAP:    wrap    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[4:2])
      REG_AMBIENT: prdata = {24'd0, ambient};
      REG_SHADE:   prdata = {16'd0, shade};
      REG_LDIR_X:  prdata = 32'(ldir_x);
      REG_LDIR_Y:  prdata = 32'(ldir_y);
      REG_LDIR_Z:  prdata = 32'(ldir_z);
      REG_WRAP:    prdata = {16'd0, wrap};
      default:     prdata = 32'd0;
    endcase
  end

  // effective wrap factor and its excess over 1.0
  logic [15:0] wfac;
  logic [15:0] wbase;
  assign wfac  = (wrap < WRAP_ONE) ? WRAP_ONE : wrap;
  assign wbase = wfac - WRAP_ONE;

  // --------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------
  logic [NST:1]   v;
  logic [NST+1:1] rdy;
  item_t          it [NST:1];
  logic           accept;

  assign rdy[NST+1] = out_ready;
  genvar s;
  generate
    for (s = 1; s <= NST; s++) begin : g_rdy
      assign rdy[s] = !v[s] || rdy[s+1];
    end
  endgenerate

  assign in_ready = rdy[1];
  assign accept   = in_valid && rdy[1];

  // advance valid bits; only results occupy the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int i = 2; i < NST; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
      if (rdy[NST]) begin
        v[NST] <= v[NST-1] &&
                  ((it[NST-1].cmd == CMD_TRANSFORM) || (it[NST-1].cmd == CMD_LIGHT));
      end
    end
  end

  // --------------------------------------------------------------------
  // Stage 1: capture item, read matrix
  // --------------------------------------------------------------------
  logic [BAW+6:0]               bone_ext;
  logic [BAW-1:0]               bone_addr;
  logic                         bone_ok;
  logic                         bok1;
  mat_wr_t                      mwr;
  logic [MAT_WORDS-1:0][31:0]   mat_rd;

  assign bone_ext  = {{BAW{1'b0}}, bone};
  assign bone_addr = bone_ext[BAW-1:0];
  assign bone_ok   = ({2'b00, bone} < 9'(NUM_BONES));

  assign mwr.en   = accept && (cmd == CMD_LOAD_MAT) && bone_ok && (slot < 8'(MAT_WORDS));
  assign mwr.word = slot[3:0];
  assign mwr.data = load_value;

  vsl_bone_store #(
    .NUM_BONES(NUM_BONES)
  ) u_store (
    .clk   (clk),
    .wr    (mwr),
    .waddr (bone_addr),
    .rd_en (rdy[1]),
    .raddr (bone_addr),
    .rdata (mat_rd)
  );

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      it[1].cmd  <= cmd;
      it[1].slot <= slot;
      it[1].gval <= load_value[9:0];
      it[1].flat <= flat_shade;
      it[1].x    <= vec_x;
      it[1].y    <= vec_y;
      it[1].z    <= vec_z;
      bok1       <= bone_ok;
    end
  end

  // --------------------------------------------------------------------
  // Stage 2: nine row products and translation
  // --------------------------------------------------------------------
  logic signed [31:0] mw   [MAT_WORDS];
  logic signed [31:0] vin  [3];
  logic signed [63:0] prod [9];
  logic signed [31:0] tr   [3];

  // zero the matrix of a bone beyond the store
  always_comb begin
    for (int w = 0; w < MAT_WORDS; w++) begin
      mw[w] = bok1 ? $signed(mat_rd[w]) : 32'sd0;
    end
    vin[0] = it[1].x;
    vin[1] = it[1].y;
    vin[2] = it[1].z;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      it[2] <= it[1];
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r*3+c] <= mw[r*4+c] * vin[c];
        end
        tr[r] <= (it[1].cmd == CMD_TRANSFORM) ? mw[r*4+3] : 32'sd0;
      end
    end
  end

  // --------------------------------------------------------------------
  // Stage 3: row sums, floor to Q16.16, saturate
  // --------------------------------------------------------------------
  function automatic logic signed [31:0] sat32(input logic signed [49:0] a);
    if (a > 50'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (a < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return a[31:0];
  endfunction

  logic signed [65:0] rsum [3];
  logic signed [31:0] rsat [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = 66'(prod[r*3]) + 66'(prod[r*3+1]) + 66'(prod[r*3+2]) +
                $signed({{18{tr[r][31]}}, tr[r], 16'd0});
      rsat[r] = sat32($signed(rsum[r][65:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      it[3].cmd  <= it[2].cmd;
      it[3].slot <= it[2].slot;
      it[3].gval <= it[2].gval;
      it[3].flat <= it[2].flat;
      it[3].x    <= rsat[0];
      it[3].y    <= rsat[1];
      it[3].z    <= rsat[2];
    end
  end

  // --------------------------------------------------------------------
  // Stage 4: light direction products
  // --------------------------------------------------------------------
  logic signed [47:0] dp [3];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      it[4] <= it[3];
      dp[0] <= ldir_x * it[3].x;
      dp[1] <= ldir_y * it[3].y;
      dp[2] <= ldir_z * it[3].z;
    end
  end

  // --------------------------------------------------------------------
  // Stage 5: dot product and wrapped numerator
  // --------------------------------------------------------------------
  logic signed [49:0] dot;
  logic signed [50:0] num;
  logic [49:0]        numu5;

  assign dot = 50'(dp[0]) + 50'(dp[1]) + 50'(dp[2]);
  assign num = $signed({13'd0, wbase, 22'd0}) - 51'(dot);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      it[5] <= it[4];
      // drop a numerator that is not positive
      numu5 <= (!num[50] && (num != 51'sd0)) ? num[49:0] : 50'd0;
    end
  end

  // --------------------------------------------------------------------
  // Stage 6: scale by shade level
  // --------------------------------------------------------------------
  logic [65:0] nprod6;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      it[6]  <= it[5];
      nprod6 <= 66'(shade) * 66'(numu5);
    end
  end

  // --------------------------------------------------------------------
  // Stage 7: saturation check; stages 8 to 15: one quotient bit each
  // --------------------------------------------------------------------
  logic [53:0]   qrem [NST-2:7];
  logic [QB-1:0] qbit [NST-2:7];
  logic          qcap [NST-2:7];

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      it[7]   <= it[6];
      qcap[7] <= (nprod6 >= 66'({wfac, 38'd0}));
      qrem[7] <= nprod6[53:0];
      qbit[7] <= '0;
    end
  end

  generate
    for (s = 8; s < 8 + QB; s++) begin : g_div
      localparam int J = 7 + QB - s;
      logic [53:0] dv;
      logic        ge;
      assign dv = 54'(wfac) << (30 + J);
      assign ge = (qrem[s-1] >= dv);

      // subtract the shifted divisor where it fits
      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          it[s]   <= it[s-1];
          qcap[s] <= qcap[s-1];
          qrem[s] <= ge ? (qrem[s-1] - dv) : qrem[s-1];
          qbit[s] <= qbit[s-1] | (ge ? (QB'(1) << J) : QB'(0));
        end
      end
    end
  endgenerate

  // --------------------------------------------------------------------
  // Stage 16: illumination, clamped to 255
  // --------------------------------------------------------------------
  localparam int QL = 7 + QB;
  logic [7:0] add16;
  logic [8:0] isum;
  logic [7:0] illum16;

  always_comb begin
    if (it[QL].flat) begin
      add16 = {1'b0, shade[15:9]};
    end else if (qcap[QL]) begin
      add16 = 8'd255;
    end else begin
      add16 = qbit[QL];
    end
    isum = {1'b0, ambient} + {1'b0, add16};
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      it[NST-1] <= it[QL];
      illum16   <= isum[8] ? 8'd255 : isum[7:0];
    end
  end

  // --------------------------------------------------------------------
  // Stage 17: gamma table write and lookup, output register
  // --------------------------------------------------------------------
  logic [9:0] gamma [GAMMA_DEPTH];
  logic [9:0] glvl;

  always_ff @(posedge clk) begin
    if (rdy[NST]) begin
      if (v[NST-1] && (it[NST-1].cmd == CMD_LOAD_GAMMA)) begin
        gamma[it[NST-1].slot] <= it[NST-1].gval;
      end
      glvl    <= gamma[illum16];
      it[NST] <= it[NST-1];
    end
  end

  assign out_valid   = v[NST];
  assign out_x       = (it[NST].cmd == CMD_TRANSFORM) ? it[NST].x : 32'sd0;
  assign out_y       = (it[NST].cmd == CMD_TRANSFORM) ? it[NST].y : 32'sd0;
  assign out_z       = (it[NST].cmd == CMD_TRANSFORM) ? it[NST].z : 32'sd0;
  assign light_level = (it[NST].cmd == CMD_LIGHT) ? glvl : 10'd0;

endmodule

### hdl/vsl_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsl_checker: port-level checks for the vertex skin and light block
// Watches the top level ports and flags stalls, field mixing, reset and
// ambient register readback errors.
// ---------------------------------------------------------------------------
module vsl_checker
  import vsl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic [9:0]  light_level,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
                                $stable(out_z) && $stable(light_level))
    else $error("stalled result changed");

  // a transformed vertex carries no light level
  a_field_mix: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_x != 32'd0 || out_y != 32'd0 || out_z != 32'd0)
      |-> light_level == 10'd0)
    else $error("result mixes vertex and light fields");

  // drop every result on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // read back an ambient write
  a_ambient_rb: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[4:2] == REG_AMBIENT
      |=> paddr[4:2] != REG_AMBIENT || prdata == {24'd0, $past(pwdata[7:0])})
    else $error("ambient level readback mismatch");

endmodule

bind vertex_skin_and_light vsl_checker u_vsl_checker (.*);
